@@ hw/rtl/dmp_pkg.sv @@
// Shared types, character codes and helper functions of the debug memory packet parser.
`default_nettype none
package dmp_pkg;

  localparam int HEX_DIGITS_MAX = 8;
  localparam int DCNT_W = 4;

  localparam logic [7:0] CH_CMD_WR = 8'h4D;  // 'M'
  localparam logic [7:0] CH_CMD_RD = 8'h6D;  // 'm'
  localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
  localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF = 8'h66;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [31:0] MAX_LEN_RESET = 32'd4096;
  localparam logic [31:0] WR_LEN_LIMIT = 32'h7FFF_FFFF;
  localparam logic [32:0] ADDR_SPAN = 33'h1_0000_0000;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW = 2;
  localparam int Q_CW = 3;

  typedef struct packed {
    logic       eop;
    logic       is_cmd_rd;
    logic       is_cmd_wr;
    logic       is_comma;
    logic       is_colon;
    logic       is_hex;
    logic [3:0] nib;
  } token_t;

  function automatic token_t classify(input logic [7:0] c, input logic eop);
    token_t t;
    logic [7:0] d;
    t = '0;
    d = '0;
    t.eop = eop;
    t.is_cmd_rd = (c == CH_CMD_RD);
    t.is_cmd_wr = (c == CH_CMD_WR);
    t.is_comma = (c == CH_COMMA);
    t.is_colon = (c == CH_COLON);
    if (c >= CH_0 && c <= CH_9) begin
      t.is_hex = 1'b1;
      d = c - CH_0;
    end else if (c >= CH_LA && c <= CH_LF) begin
      t.is_hex = 1'b1;
      d = c - CH_LA + 8'd10;
    end else if (c >= CH_UA && c <= CH_UF) begin
      t.is_hex = 1'b1;
      d = c - CH_UA + 8'd10;
    end
    t.nib = d[3:0];
    return t;
  endfunction

  function automatic logic in_range(input logic [31:0] addr, input logic [31:0] len,
                                    input logic [31:0] max_len, input logic wr);
    logic [32:0] span;
    span = {1'b0, addr} + {1'b0, len};
    return !(len > max_len) && !(span > ADDR_SPAN) && !(wr && (len > WR_LEN_LIMIT));
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/debug_memory_packet_parser.sv @@
// Top level of the debug memory packet parser: classifier, token queue and parser.
// One packet character is accepted per cycle while the token queue is not full. A
// four-entry token queue separates the classifier from the parser, whose results
// go to the output register. A write packet's final data character that also ends
// the packet yields a data byte and the verdict; the verdict is held behind the
// byte. Data bytes of a packet whose verdict rejects it must be dropped by the
// consumer. The maximum transfer length resets to 4096; the user must write it via
// cfg_wr_en/cfg_wr_data only while idle, which the block leaves unchecked.
`default_nettype none
module debug_memory_packet_parser (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_wr_en,
  input  wire logic [31:0]  cfg_wr_data,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [7:0]   in_char_code,
  input  wire logic         in_end_of_packet,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic              out_result_kind,
  output logic              out_accepted,
  output logic              out_is_write,
  output logic [31:0]       out_address,
  output logic [31:0]       out_length,
  output logic [7:0]        out_data_byte,
  output logic              out_last_of_run
);

  logic q_full;
  logic q_push;
  dmp_pkg::token_t q_push_tok;
  logic q_pop;
  logic q_valid;
  dmp_pkg::token_t q_tok;

  dmp_front u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_code    (in_char_code),
    .in_end_of_packet(in_end_of_packet),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_push_tok      (q_push_tok)
  );

  dmp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_tok  (q_push_tok),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_tok  (q_tok)
  );

  dmp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .q_valid        (q_valid),
    .q_tok          (q_tok),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_kind(out_result_kind),
    .out_accepted   (out_accepted),
    .out_is_write   (out_is_write),
    .out_address    (out_address),
    .out_length     (out_length),
    .out_data_byte  (out_data_byte),
    .out_last_of_run(out_last_of_run)
  );

endmodule
`default_nettype wire

@@ hw/rtl/dmp_front.sv @@
// Front end: takes packet characters and classifies them into tokens for the queue.
`default_nettype none
module dmp_front (
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic [7:0]     in_char_code,
  input  wire logic           in_end_of_packet,
  input  wire logic           q_full,
  output logic                q_push,
  output dmp_pkg::token_t     q_push_tok
);

  assign in_stall = q_full;
  assign q_push = in_valid && !q_full;
  assign q_push_tok = dmp_pkg::classify(in_char_code, in_end_of_packet);

endmodule
`default_nettype wire

@@ hw/rtl/dmp_queue.sv @@
// Short token queue between the classifier and the parser.
`default_nettype none
module dmp_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire dmp_pkg::token_t  push_tok,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output dmp_pkg::token_t       head_tok
);

  dmp_pkg::token_t mem_r [dmp_pkg::Q_DEPTH];
  logic [dmp_pkg::Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [dmp_pkg::Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [dmp_pkg::Q_CW-1:0] count_r, count_nxt;

  assign full = (count_r == dmp_pkg::Q_CW'(dmp_pkg::Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_tok = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/dmp_back.sv @@
// Back end: packet state machine, range checks and the result output register.
`default_nettype none
module dmp_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [31:0]      cfg_wr_data,
  input  wire logic             q_valid,
  input  wire dmp_pkg::token_t  q_tok,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_result_kind,
  output logic                  out_accepted,
  output logic                  out_is_write,
  output logic [31:0]           out_address,
  output logic [31:0]           out_length,
  output logic [7:0]            out_data_byte,
  output logic                  out_last_of_run
);

  localparam logic [1:0] PH_CMD = 2'd0;
  localparam logic [1:0] PH_ADDR = 2'd1;
  localparam logic [1:0] PH_LEN = 2'd2;
  localparam logic [1:0] PH_DATA = 2'd3;

  logic [31:0] max_len_r;

  logic [1:0] phase_r, phase_nxt;
  logic wm_r, wm_nxt;
  logic err_r, err_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [dmp_pkg::DCNT_W-1:0] acnt_r, acnt_nxt;
  logic [31:0] len_r, len_nxt;
  logic [dmp_pkg::DCNT_W-1:0] lcnt_r, lcnt_nxt;
  logic [3:0] hi_r, hi_nxt;
  logic hpend_r, hpend_nxt;
  logic [31:0] bcnt_r, bcnt_nxt;

  logic emit_byte;
  logic ok;
  logic [7:0] byte_val;
  logic slot_free;

  logic out_valid_r;
  logic out_kind_r, out_acc_r, out_wr_r, out_last_r;
  logic [31:0] out_addr_r, out_len_r;
  logic [7:0] out_byte_r;

  logic pend_valid_r;
  logic pend_acc_r, pend_wr_r;
  logic [31:0] pend_addr_r, pend_len_r;

  localparam logic [dmp_pkg::DCNT_W-1:0] DIG_MAX = dmp_pkg::DCNT_W'(dmp_pkg::HEX_DIGITS_MAX);

  assign slot_free = !out_valid_r || !out_stall;
  assign q_pop = q_valid && slot_free && !pend_valid_r;
  assign byte_val = {hi_r, q_tok.nib};

  // Values before the end-of-packet clear.
  function automatic logic wm_nxt_pre();
    return (phase_r == PH_CMD) ? q_tok.is_cmd_wr : wm_r;
  endfunction

  function automatic logic [31:0] addr_nxt_pre();
    return (phase_r == PH_ADDR && !err_r && q_tok.is_hex && !q_tok.is_comma &&
            acnt_r < DIG_MAX) ? {addr_r[27:0], q_tok.nib} : addr_r;
  endfunction

  function automatic logic [31:0] len_nxt_pre();
    return (phase_r == PH_LEN && !err_r && q_tok.is_hex && !(wm_r && q_tok.is_colon) &&
            lcnt_r < DIG_MAX) ? {len_r[27:0], q_tok.nib} : len_r;
  endfunction

  always_comb begin
    phase_nxt = phase_r;
    wm_nxt = wm_r;
    err_nxt = err_r;
    addr_nxt = addr_r;
    acnt_nxt = acnt_r;
    len_nxt = len_r;
    lcnt_nxt = lcnt_r;
    hi_nxt = hi_r;
    hpend_nxt = hpend_r;
    bcnt_nxt = bcnt_r;
    emit_byte = 1'b0;
    ok = 1'b0;
    unique case (phase_r)
      PH_CMD: begin
        wm_nxt = q_tok.is_cmd_wr;
        if (!(q_tok.is_cmd_rd || q_tok.is_cmd_wr)) begin
          err_nxt = 1'b1;
        end
        phase_nxt = PH_ADDR;
      end
      PH_ADDR: begin
        if (!err_r) begin
          if (q_tok.is_comma) begin
            if (acnt_r == '0) err_nxt = 1'b1;
            else phase_nxt = PH_LEN;
          end else if (!q_tok.is_hex || acnt_r >= DIG_MAX) begin
            err_nxt = 1'b1;
          end else begin
            addr_nxt = {addr_r[27:0], q_tok.nib};
            acnt_nxt = acnt_r + 1'b1;
          end
        end
      end
      PH_LEN: begin
        if (!err_r) begin
          if (wm_r && q_tok.is_colon) begin
            if (lcnt_r == '0 || !dmp_pkg::in_range(addr_r, len_r, max_len_r, wm_r)) begin
              err_nxt = 1'b1;
            end else begin
              phase_nxt = PH_DATA;
            end
          end else if (!q_tok.is_hex || lcnt_r >= DIG_MAX) begin
            err_nxt = 1'b1;
          end else begin
            len_nxt = {len_r[27:0], q_tok.nib};
            lcnt_nxt = lcnt_r + 1'b1;
          end
        end
      end
      PH_DATA: begin
        if (!err_r) begin
          if (!q_tok.is_hex || bcnt_r >= len_r) begin
            err_nxt = 1'b1;
          end else if (!hpend_r) begin
            hi_nxt = q_tok.nib;
            hpend_nxt = 1'b1;
          end else begin
            emit_byte = 1'b1;
            hpend_nxt = 1'b0;
            bcnt_nxt = bcnt_r + 1'b1;
          end
        end
      end
    endcase

    if (!err_nxt) begin
      if (phase_nxt == PH_LEN && !wm_nxt) begin
        ok = (lcnt_nxt != '0) && dmp_pkg::in_range(addr_nxt, len_nxt, max_len_r, wm_nxt);
      end else if (phase_nxt == PH_DATA) begin
        ok = !hpend_nxt && (bcnt_nxt == len_nxt);
      end
    end

    if (q_tok.eop) begin
      phase_nxt = PH_CMD;
      err_nxt = 1'b0;
      addr_nxt = '0;
      acnt_nxt = '0;
      len_nxt = '0;
      lcnt_nxt = '0;
      hi_nxt = '0;
      hpend_nxt = 1'b0;
      bcnt_nxt = '0;
      wm_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= dmp_pkg::MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CMD;
      wm_r <= 1'b0;
      err_r <= 1'b0;
      addr_r <= '0;
      acnt_r <= '0;
      len_r <= '0;
      lcnt_r <= '0;
      hi_r <= '0;
      hpend_r <= 1'b0;
      bcnt_r <= '0;
    end else if (q_pop) begin
      phase_r <= phase_nxt;
      wm_r <= wm_nxt;
      err_r <= err_nxt;
      addr_r <= addr_nxt;
      acnt_r <= acnt_nxt;
      len_r <= len_nxt;
      lcnt_r <= lcnt_nxt;
      hi_r <= hi_nxt;
      hpend_r <= hpend_nxt;
      bcnt_r <= bcnt_nxt;
    end
  end

  // Output register plus one held verdict when a character yields a byte and a verdict.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_valid_r <= 1'b0;
    end else if (slot_free) begin
      if (pend_valid_r) begin
        out_valid_r <= 1'b1;
        pend_valid_r <= 1'b0;
      end else if (q_pop) begin
        out_valid_r <= emit_byte || q_tok.eop;
        pend_valid_r <= emit_byte && q_tok.eop;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (pend_valid_r) begin
        out_kind_r <= dmp_pkg::KIND_VERDICT;
        out_acc_r <= pend_acc_r;
        out_wr_r <= pend_wr_r;
        out_addr_r <= pend_addr_r;
        out_len_r <= pend_len_r;
        out_byte_r <= '0;
        out_last_r <= 1'b1;
      end else if (q_pop && emit_byte) begin
        out_kind_r <= dmp_pkg::KIND_BYTE;
        out_acc_r <= 1'b0;
        out_wr_r <= 1'b1;
        out_addr_r <= '0;
        out_len_r <= '0;
        out_byte_r <= byte_val;
        out_last_r <= !q_tok.eop;
      end else if (q_pop && q_tok.eop) begin
        out_kind_r <= dmp_pkg::KIND_VERDICT;
        out_acc_r <= ok;
        out_wr_r <= wm_nxt_pre();
        out_addr_r <= ok ? addr_nxt_pre() : '0;
        out_len_r <= ok ? len_nxt_pre() : '0;
        out_byte_r <= '0;
        out_last_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit_byte && q_tok.eop) begin
      pend_acc_r <= ok;
      pend_wr_r <= wm_nxt_pre();
      pend_addr_r <= ok ? addr_nxt_pre() : '0;
      pend_len_r <= ok ? len_nxt_pre() : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_accepted = out_acc_r;
  assign out_is_write = out_wr_r;
  assign out_address = out_addr_r;
  assign out_length = out_len_r;
  assign out_data_byte = out_byte_r;
  assign out_last_of_run = out_last_r;

  a_pend_behind_byte: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (out_valid_r && out_kind_r == dmp_pkg::KIND_BYTE && !out_last_r))
    else $error("held verdict without a byte in the output register");

  a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == dmp_pkg::KIND_VERDICT) |-> out_last_r)
    else $error("verdict not marked last");

  a_cmd_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_CMD) |-> (bcnt_r == '0 && !hpend_r && !err_r && acnt_r == '0))
    else $error("packet state not cleared at command phase");

  a_no_pop_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(phase_r))
    else $error("parser advanced while output stalled");

endmodule
`default_nettype wire
